/* rtl/ordered_record_table_assert.svh */
// Assertion macros for the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ORDERED_RECORD_TABLE_ASSERT_SVH
`define ORDERED_RECORD_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ORT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ordered_record_table check failed");
`define ORT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ordered_record_table check failed");
`else
`define ORT_ASSERT_IMP(lbl, ante, cons)
`define ORT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/ort_pkg.sv */
package ort_pkg;

    localparam int NUM_FIELDS = 4;
    localparam int FIELD_BITS = 16;
    localparam int NF_W       = 3;
    localparam int POS_W      = 7;
    localparam int IDX_IN_W   = 6;

    typedef logic [NUM_FIELDS-1:0][FIELD_BITS-1:0] t_record;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_GET    = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_REMOVE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef struct packed {
        logic            load_match;
        logic            write;
        logic            shift;
        logic [NF_W-1:0] nf;
    } t_cell_ctl;

endpackage

/* rtl/ort_cell.sv */
module ort_cell (
    input  logic               i_clk,
    input  ort_pkg::t_cell_ctl i_ctl,
    input  ort_pkg::t_record   i_cmp_key,
    input  ort_pkg::t_record   i_wr_key,
    input  ort_pkg::t_record   i_next,
    output ort_pkg::t_record   o_rec,
    output logic               o_match
);
    import ort_pkg::*;

    t_record r_rec;
    logic    r_match;
    logic    w_eq;

    // Compare only the fields in use.
    always_comb begin
        w_eq = 1'b1;
        for (int f = 0; f < NUM_FIELDS; f++) begin
            if (NF_W'(f) < i_ctl.nf && r_rec[f] != i_cmp_key[f]) begin
                w_eq = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_match) begin
            r_match <= w_eq;
        end
        if (i_ctl.write) begin
            r_rec <= i_wr_key;
        end else if (i_ctl.shift) begin
            r_rec <= i_next;
        end
    end

    assign o_rec   = r_rec;
    assign o_match = r_match;

endmodule

/* rtl/ordered_record_table.sv */
// Each item is taken in a compare cycle, in which every cell matches the key at
// once, then resolved in a resolve cycle that picks the first hit, writes or
// shifts the cells and registers the result once the result register is free.
// A new item is not taken until the last one is resolved. A stalled result
// holds off the resolve cycle.
// Reset (synchronous, active low) empties the table, sets fields_in_use to 4
// and drops any pending result; record contents are not cleared.
`include "ordered_record_table_assert.svh"

module ordered_record_table #(
    parameter int CAPACITY = 64   // 2 to 64 records
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: fields_in_use
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    // Request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [5:0]  i_entry_index,
    input  logic [15:0] i_key_field_0,
    input  logic [15:0] i_key_field_1,
    input  logic [15:0] i_key_field_2,
    input  logic [15:0] i_key_field_3,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [6:0]  o_position,
    output logic [6:0]  o_entry_count,
    output logic [15:0] o_out_field_0,
    output logic [15:0] o_out_field_1,
    output logic [15:0] o_out_field_2,
    output logic [15:0] o_out_field_3
);
    import ort_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // The controller alternates between taking an item (and latching the
    // per-cell compare results) and resolving it against the cell row.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RES  = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [NF_W-1:0]      r_fields_in_use;
    logic [CNT_W-1:0]     r_count, n_count;
    t_req                 r_req;
    logic [IDX_IN_W-1:0]  r_idx;
    t_record              r_key;

    logic                 r_out_valid, n_out_valid;
    t_status              r_status, n_status;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [POS_W-1:0]     r_cnt_out;
    t_record              r_field, n_field;

    t_record              w_in_key;
    t_record              w_rec [CAPACITY];
    logic [CAPACITY-1:0]  w_match_raw;
    logic [CAPACITY-1:0]  w_match;
    logic [CAPACITY-1:0]  w_lowest;
    logic [CAPACITY-1:0]  w_at_or_above;
    logic [CAPACITY-1:0]  w_write;
    logic [CAPACITY-1:0]  w_shift;
    logic [IDX_W-1:0]     w_hit_idx;
    logic                 w_hit_any;
    t_record              w_hit_rec;
    t_record              w_sel_rec;
    logic                 w_sel_en;
    logic [NF_W-1:0]      w_nf;
    logic                 w_accept;
    logic                 w_res_go;
    logic                 w_full;
    logic [POS_W-1:0]     w_idx_ext;
    logic [POS_W-1:0]     w_count_ext;
    logic [IDX_W-1:0]     w_get_idx;

    assign w_in_key = {i_key_field_3, i_key_field_2, i_key_field_1, i_key_field_0};

    // A field count of zero acts as one; anything above the field count of a
    // record is clipped to it.
    always_comb begin
        if (r_fields_in_use == '0) begin
            w_nf = NF_W'(1);
        end else if (r_fields_in_use > NF_W'(NUM_FIELDS)) begin
            w_nf = NF_W'(NUM_FIELDS);
        end else begin
            w_nf = r_fields_in_use;
        end
    end

    // The request channel is held off while reset is applied.
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_res_go    = (r_state == S_RES) && (!r_out_valid || i_out_ready);
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_idx_ext   = POS_W'(r_idx);
    assign w_count_ext = POS_W'(r_count);
    assign w_get_idx   = w_idx_ext[IDX_W-1:0];

    // Row of cells. Each cell holds one record and its compare result; on a
    // remove, every cell from the hit upward takes its upper neighbor's record.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_cell_ctl w_ctl;
        t_record   w_next;

        if (i == CAPACITY - 1) begin : g_top
            assign w_next = w_rec[i];
        end else begin : g_mid
            assign w_next = w_rec[i+1];
        end

        assign w_write[i] = w_res_go && (r_req == REQ_INSERT) && !w_full
                            && (r_count == CNT_W'(i));
        assign w_shift[i] = w_res_go && (r_req == REQ_REMOVE) && w_hit_any
                            && w_at_or_above[i];
        assign w_match[i] = w_match_raw[i] && (r_count > CNT_W'(i));

        assign w_ctl.load_match = w_accept;
        assign w_ctl.write      = w_write[i];
        assign w_ctl.shift      = w_shift[i];
        assign w_ctl.nf         = w_nf;

        ort_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_cmp_key (w_in_key),
            .i_wr_key  (r_key),
            .i_next    (w_next),
            .o_rec     (w_rec[i]),
            .o_match   (w_match_raw[i])
        );
    end

    // First hit: isolate the lowest set match bit; the match bits ORed with
    // their two's complement give everything at or above it, the span that
    // shifts down on a remove.
    assign w_hit_any     = |w_match;
    assign w_lowest      = w_match & (~w_match + CAPACITY'(1));
    assign w_at_or_above = w_match | (~w_match + CAPACITY'(1));

    always_comb begin
        w_hit_idx = '0;
        w_hit_rec = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_lowest[i]) begin
                w_hit_idx = w_hit_idx | IDX_W'(i);
                w_hit_rec = w_hit_rec | w_rec[i];
            end
        end
    end

    // Resolve the latched request.
    always_comb begin
        n_status  = ST_OK;
        n_pos     = '0;
        n_count   = r_count;
        w_sel_rec = '0;
        w_sel_en  = 1'b0;
        unique case (r_req)
            REQ_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    n_pos   = w_count_ext + POS_W'(1);
                end
            end
            REQ_GET: begin
                if (w_idx_ext >= w_count_ext) begin
                    n_status = ST_RANGE;
                end else begin
                    n_pos     = w_idx_ext;
                    w_sel_rec = w_rec[w_get_idx];
                    w_sel_en  = 1'b1;
                end
            end
            REQ_FIND: begin
                if (w_hit_any) begin
                    n_pos = POS_W'(w_hit_idx);
                end else begin
                    n_status = ST_NOMATCH;
                end
            end
            REQ_REMOVE: begin
                if (w_hit_any) begin
                    n_pos     = POS_W'(w_hit_idx);
                    w_sel_rec = w_hit_rec;
                    w_sel_en  = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_NOMATCH;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase

        // Fields beyond the count in use read as zero.
        for (int f = 0; f < NUM_FIELDS; f++) begin
            n_field[f] = (w_sel_en && NF_W'(f) < w_nf) ? w_sel_rec[f] : '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (w_res_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_go) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_count         <= '0;
            r_fields_in_use <= NF_W'(NUM_FIELDS);
            r_out_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_res_go) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_fields_in_use <= i_cfg_wdata;
            end
        end
    end

    // Request latch and result register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= t_req'(i_req_type);
            r_idx <= i_entry_index;
            r_key <= w_in_key;
        end
        if (w_res_go) begin
            r_status  <= n_status;
            r_pos     <= n_pos;
            r_cnt_out <= POS_W'(n_count);
            r_field   <= n_field;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_position    = r_pos;
    assign o_entry_count = r_cnt_out;
    assign o_out_field_0 = r_field[0];
    assign o_out_field_1 = r_field[1];
    assign o_out_field_2 = r_field[2];
    assign o_out_field_3 = r_field[3];

    // The count never runs past the number of cells.
    `ORT_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY))
    // At most one cell takes an inserted record, and never during a shift.
    `ORT_ASSERT_IMP(a_one_write, 1'b1, $onehot0(w_write) && !((|w_write) && (|w_shift)))
    // A successful insert grows the table by exactly one record.
    `ORT_ASSERT_NXT(a_insert_grows, w_res_go && r_req == REQ_INSERT && !w_full,
                    r_count == $past(r_count) + CNT_W'(1))
    // An accepted item is always followed by its resolve cycle.
    `ORT_ASSERT_NXT(a_accept_to_res, w_accept, r_state == S_RES && !o_in_ready)

endmodule
